// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property at every rising clock edge outside reset.
`define ASSERT_CLKD(lbl, clk, rstn, prop) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
    else $error("assertion failed");

// Check a property at every rising clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) (prop)) else $error("assertion failed");

`endif

// ===== rtl/bptc_pkg.sv =====
// Package: types, constants and arithmetic helpers of the compensation pipeline.
`default_nettype none
package bptc_pkg;

  localparam int unsigned DataW   = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgW    = 64;

  localparam logic [31:0] TempOff = 32'd4000;
  localparam logic [31:0] B4Bias  = 32'd32768;
  localparam logic [31:0] B7Scale = 32'd50000;
  localparam logic [31:0] QuadC2  = 32'd3038;
  localparam logic [31:0] QuadC1  = 32'hFFFF_E343;
  localparam logic [31:0] QuadC0  = 32'd3791;

  typedef enum logic [CfgIdxW-1:0] {
    REG_CAL_A = 2'd0,
    REG_CAL_B = 2'd1,
    REG_CAL_C = 2'd2,
    REG_OSS   = 2'd3
  } cfg_reg_e;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

  typedef struct packed {
    logic [15:0] ut;
    logic [31:0] up;
    logic [31:0] x1;
    logic [31:0] x2;
    logic [31:0] x3;
    logic [31:0] sq;
    logic [31:0] b3;
    logic [31:0] b4;
    logic [31:0] b7;
    logic [31:0] t;
    logic [31:0] p;
    logic [31:0] dvd;
    logic [31:0] dvs;
    logic        neg;
    logic        big;
    logic        fault;
  } item_t;

  function automatic logic [31:0] sx16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
    logic [63:0] prod;
    prod = {32'd0, a} * {32'd0, b};
    return prod[31:0];
  endfunction

  // Signed division by 2^k, truncating toward zero.
  function automatic logic [31:0] sdiv_p2(input logic [31:0] a, input int unsigned k);
    logic [31:0] bias;
    logic [31:0] s;
    bias = a[31] ? ((32'd1 << k) - 32'd1) : 32'd0;
    s = a + bias;
    return 32'($signed(s) >>> k);
  endfunction

endpackage
`default_nettype wire

// ===== rtl/baro_temp_pressure_compensation.sv =====
// Barometric temperature and pressure compensation: one reading pair per clock
// through an 81-stage pipeline (3 front stages, a 32-stage divider for X2, 9 middle
// stages, a 32-stage divider for B7/B4, 5 back stages). While an output word
// waits, the whole pipeline holds and the input side is not ready.
// Calibration and oversampling registers are written through the cfg port, which
// is always ready; write them only while no reading is in flight.
`default_nettype none
module baro_temp_pressure_compensation import bptc_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               s_axis_tvalid_i,
  output logic                    s_axis_tready_o,
  input  wire logic [39:0]        s_axis_tdata_i,   // temp_raw[15:0], press_raw[39:16]
  output logic                    m_axis_tvalid_o,
  input  wire logic               m_axis_tready_i,
  output logic [63:0]             m_axis_tdata_o,   // temp_tenths[31:0], press_pa[63:32]
  output logic [0:0]              m_axis_tuser_o,   // div_fault[0]
  input  wire logic               cfg_valid_i,
  output logic                    cfg_ready_o,
  input  wire logic [CfgIdxW-1:0] cfg_index_i,
  input  wire logic [CfgW-1:0]    cfg_data_i
);

  logic [63:0] cal_a_q;
  logic [63:0] cal_b_q;
  logic [31:0] cal_c_q;
  logic [1:0]  oss_q;
  cal_t        cal;
  logic        en;

  logic  fr_vld, d1_vld, md_vld, d2_vld, bk_vld;
  item_t fr_item, d1_item, md_item, d2_item, bk_item;
  logic [31:0] d1_quot, d2_quot;
  logic [$bits(item_t)-1:0] d1_pay, d2_pay;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cal_a_q <= '0;
      cal_b_q <= '0;
      cal_c_q <= '0;
      oss_q   <= 2'd1;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_CAL_A: cal_a_q <= cfg_data_i;
        REG_CAL_B: cal_b_q <= cfg_data_i;
        REG_CAL_C: cal_c_q <= cfg_data_i[31:0];
        REG_OSS:   oss_q   <= cfg_data_i[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    cal.ac1 = cal_a_q[15:0];
    cal.ac2 = cal_a_q[31:16];
    cal.ac3 = cal_a_q[47:32];
    cal.ac4 = cal_a_q[63:48];
    cal.ac5 = cal_b_q[15:0];
    cal.ac6 = cal_b_q[31:16];
    cal.b1  = cal_b_q[47:32];
    cal.b2  = cal_b_q[63:48];
    cal.mc  = cal_c_q[15:0];
    cal.md  = cal_c_q[31:16];
    cal.oss = oss_q;
  end

  assign en              = !m_axis_tvalid_o || m_axis_tready_i;
  assign s_axis_tready_o = en;

  bptc_front u_front (
    .clk_i,
    .rst_ni,
    .en_i        (en),
    .valid_i     (s_axis_tvalid_i),
    .temp_raw_i  (s_axis_tdata_i[15:0]),
    .press_raw_i (s_axis_tdata_i[39:16]),
    .cal_i       (cal),
    .valid_o     (fr_vld),
    .item_o      (fr_item)
  );

  bptc_div #(.W(DataW), .PW($bits(item_t))) u_div_temp (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (fr_vld),
    .dividend_i (fr_item.dvd),
    .divisor_i  (fr_item.dvs),
    .payload_i  (fr_item),
    .valid_o    (d1_vld),
    .quotient_o (d1_quot),
    .payload_o  (d1_pay)
  );

  assign d1_item = item_t'(d1_pay);

  bptc_mid u_mid (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (d1_vld),
    .quot_i  (d1_quot),
    .item_i  (d1_item),
    .cal_i   (cal),
    .valid_o (md_vld),
    .item_o  (md_item)
  );

  bptc_div #(.W(DataW), .PW($bits(item_t))) u_div_press (
    .clk_i,
    .rst_ni,
    .en_i       (en),
    .valid_i    (md_vld),
    .dividend_i (md_item.dvd),
    .divisor_i  (md_item.dvs),
    .payload_i  (md_item),
    .valid_o    (d2_vld),
    .quotient_o (d2_quot),
    .payload_o  (d2_pay)
  );

  assign d2_item = item_t'(d2_pay);

  bptc_back u_back (
    .clk_i,
    .rst_ni,
    .en_i    (en),
    .valid_i (d2_vld),
    .quot_i  (d2_quot),
    .item_i  (d2_item),
    .valid_o (bk_vld),
    .item_o  (bk_item)
  );

  assign m_axis_tvalid_o = bk_vld;
  assign m_axis_tdata_o  = {bk_item.p, bk_item.t};
  assign m_axis_tuser_o  = bk_item.fault;

endmodule
`default_nettype wire

// ===== rtl/bptc_div.sv =====
// Pipelined restoring unsigned divider, one quotient bit per stage.
`default_nettype none
module bptc_div #(
  parameter int unsigned W  = 32,
  parameter int unsigned PW = 8
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          en_i,
  input  wire logic          valid_i,
  input  wire logic [W-1:0]  dividend_i,
  input  wire logic [W-1:0]  divisor_i,
  input  wire logic [PW-1:0] payload_i,
  output logic               valid_o,
  output logic [W-1:0]       quotient_o,
  output logic [PW-1:0]      payload_o
);

  logic [W-1:0]  vld_q;
  logic [W-1:0]  rem_q [W];
  logic [W-1:0]  qsh_q [W];
  logic [W-1:0]  den_q [W];
  logic [PW-1:0] pay_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic          vld_in;
    logic [W-1:0]  rem_in;
    logic [W-1:0]  qsh_in;
    logic [W-1:0]  den_in;
    logic [PW-1:0] pay_in;
    logic [W:0]    trial;
    logic          ge;
    logic [W-1:0]  rem_d;
    logic [W-1:0]  qsh_d;

    if (k == 0) begin : g_head
      assign vld_in = valid_i;
      assign rem_in = '0;
      assign qsh_in = dividend_i;
      assign den_in = divisor_i;
      assign pay_in = payload_i;
    end else begin : g_tail
      assign vld_in = vld_q[k-1];
      assign rem_in = rem_q[k-1];
      assign qsh_in = qsh_q[k-1];
      assign den_in = den_q[k-1];
      assign pay_in = pay_q[k-1];
    end

    always_comb begin
      trial = {rem_in, qsh_in[W-1]};
      ge    = trial >= {1'b0, den_in};
      rem_d = ge ? W'(trial - {1'b0, den_in}) : trial[W-1:0];
      qsh_d = {qsh_in[W-2:0], ge};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (en_i) begin
        vld_q[k] <= vld_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= rem_d;
        qsh_q[k] <= qsh_d;
        den_q[k] <= den_in;
        pay_q[k] <= pay_in;
      end
    end
  end

  assign valid_o    = vld_q[W-1];
  assign quotient_o = qsh_q[W-1];
  assign payload_o  = pay_q[W-1];

endmodule
`default_nettype wire

// ===== rtl/bptc_front.sv =====
// Front stages: pressure shift, X1 and the operands of the temperature division.
`default_nettype none
module bptc_front import bptc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [15:0] temp_raw_i,
  input  wire logic [23:0] press_raw_i,
  input  wire cal_t        cal_i,
  output logic             valid_o,
  output item_t            item_o
);

  localparam int unsigned NS = 3;

  logic [NS-1:0] vld_q;
  item_t         st_q [NS];
  item_t         st_d [NS];

  always_comb begin
    logic [3:0] sh;
    sh = 4'd8 - {2'b00, cal_i.oss};

    st_d[0]    = '0;
    st_d[0].ut = temp_raw_i;
    st_d[0].up = {8'd0, press_raw_i} >> sh;
    st_d[0].x1 = mul32({16'd0, temp_raw_i} - {16'd0, cal_i.ac6}, {16'd0, cal_i.ac5});

    st_d[1]    = st_q[0];
    st_d[1].x1 = sdiv_p2(st_q[0].x1, 15);
    st_d[1].x2 = sdiv_p2(st_q[0].x1, 15) + sx16(cal_i.md);
    st_d[1].x3 = sx16(cal_i.mc) << 11;

    st_d[2]       = st_q[1];
    st_d[2].neg   = st_q[1].x3[31] ^ st_q[1].x2[31];
    st_d[2].dvd   = st_q[1].x3[31] ? (32'd0 - st_q[1].x3) : st_q[1].x3;
    st_d[2].dvs   = st_q[1].x2[31] ? (32'd0 - st_q[1].x2) : st_q[1].x2;
    st_d[2].fault = (st_q[1].x2 == 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign item_o  = st_q[NS-1];

endmodule
`default_nettype wire

// ===== rtl/bptc_mid.sv =====
// Middle stages: B5, temperature, B6, B3, B4, B7 and the operands of the pressure division.
`default_nettype none
module bptc_mid import bptc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [31:0] quot_i,
  input  wire item_t       item_i,
  input  wire cal_t        cal_i,
  output logic             valid_o,
  output item_t            item_o
);

  localparam int unsigned NS = 9;

  logic [NS-1:0] vld_q;
  item_t         st_q [NS];
  item_t         st_d [NS];

  always_comb begin
    logic [31:0] x2q;
    logic [31:0] t1;
    logic [31:0] t2;
    logic [31:0] b3s;

    x2q = item_i.fault ? 32'd0 : (item_i.neg ? (32'd0 - quot_i) : quot_i);
    st_d[0]    = item_i;
    st_d[0].x3 = item_i.x1 + x2q;

    st_d[1]    = st_q[0];
    st_d[1].t  = sdiv_p2(st_q[0].x3 + 32'd8, 4);
    st_d[1].x3 = st_q[0].x3 - TempOff;

    st_d[2]    = st_q[1];
    st_d[2].sq = mul32(st_q[1].x3, st_q[1].x3);
    st_d[2].x2 = mul32(sx16(cal_i.ac2), st_q[1].x3);
    st_d[2].x3 = mul32(sx16(cal_i.ac3), st_q[1].x3);

    st_d[3]    = st_q[2];
    st_d[3].sq = sdiv_p2(st_q[2].sq, 12);
    st_d[3].x2 = sdiv_p2(st_q[2].x2, 11);
    st_d[3].x3 = sdiv_p2(st_q[2].x3, 13);

    st_d[4]    = st_q[3];
    st_d[4].x1 = mul32(sx16(cal_i.b2), st_q[3].sq);
    st_d[4].sq = mul32(sx16(cal_i.b1), st_q[3].sq);

    t1  = sdiv_p2(st_q[4].x1, 11);
    t2  = sdiv_p2(st_q[4].sq, 16);
    b3s = (sx16(cal_i.ac1) << 2) + t1 + st_q[4].x2;
    st_d[5]    = st_q[4];
    st_d[5].b3 = b3s << cal_i.oss;
    st_d[5].x3 = st_q[4].x3 + t2 + 32'd2;

    st_d[6]    = st_q[5];
    st_d[6].b3 = sdiv_p2(st_q[5].b3 + 32'd2, 2);
    st_d[6].x3 = sdiv_p2(st_q[5].x3, 2) + B4Bias;

    st_d[7]    = st_q[6];
    st_d[7].b4 = mul32({16'd0, cal_i.ac4}, st_q[6].x3) >> 15;
    st_d[7].b7 = mul32(st_q[6].up - st_q[6].b3, B7Scale >> cal_i.oss);

    st_d[8]       = st_q[7];
    st_d[8].big   = st_q[7].b7[31];
    st_d[8].dvd   = st_q[7].b7[31] ? st_q[7].b7 : (st_q[7].b7 << 1);
    st_d[8].dvs   = st_q[7].b4;
    st_d[8].fault = st_q[7].fault | (st_q[7].b4 == 32'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign item_o  = st_q[NS-1];

endmodule
`default_nettype wire

// ===== rtl/bptc_back.sv =====
// Back stages: pressure quotient and quadratic correction.
`default_nettype none
module bptc_back import bptc_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        en_i,
  input  wire logic        valid_i,
  input  wire logic [31:0] quot_i,
  input  wire item_t       item_i,
  output logic             valid_o,
  output item_t            item_o
);

  localparam int unsigned NS = 5;

  logic [NS-1:0] vld_q;
  item_t         st_q [NS];
  item_t         st_d [NS];

  always_comb begin
    logic [31:0] corr;

    st_d[0]   = item_i;
    st_d[0].p = (item_i.b4 == 32'd0) ? 32'd0 : (item_i.big ? (quot_i << 1) : quot_i);

    st_d[1]    = st_q[0];
    st_d[1].x1 = sdiv_p2(st_q[0].p, 8);
    st_d[1].x2 = mul32(QuadC1, st_q[0].p);

    st_d[2]    = st_q[1];
    st_d[2].x1 = mul32(st_q[1].x1, st_q[1].x1);

    st_d[3]    = st_q[2];
    st_d[3].x1 = mul32(st_q[2].x1, QuadC2);
    st_d[3].x2 = sdiv_p2(st_q[2].x2, 16);

    corr = sdiv_p2(sdiv_p2(st_q[3].x1, 16) + st_q[3].x2 + QuadC0, 4);
    st_d[4]   = st_q[3];
    st_d[4].p = st_q[3].p + corr;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[NS-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int k = 0; k < NS; k++) begin
        st_q[k] <= st_d[k];
      end
    end
  end

  assign valid_o = vld_q[NS-1];
  assign item_o  = st_q[NS-1];

endmodule
`default_nettype wire

// ===== rtl/bptc_checker.sv =====
// Port checker for the compensation pipeline, bound to the top level.
`default_nettype none
`include "assert_macros.svh"
module bptc_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tready_o,
  input wire logic        m_axis_tvalid_o,
  input wire logic        m_axis_tready_i,
  input wire logic [63:0] m_axis_tdata_o,
  input wire logic [0:0]  m_axis_tuser_o,
  input wire logic        cfg_ready_o
);

  `ASSERT_CLKD(a_out_hold, clk_i, rst_ni,
               m_axis_tvalid_o && !m_axis_tready_i |=>
               m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o))
  `ASSERT_CLKD(a_in_ready, clk_i, rst_ni,
               s_axis_tready_o == (!m_axis_tvalid_o || m_axis_tready_i))
  `ASSERT_ALWAYS(a_rst_quiet, clk_i, !rst_ni |=> !m_axis_tvalid_o)
  `ASSERT_CLKD(a_cfg_ready, clk_i, rst_ni, cfg_ready_o)

endmodule

bind baro_temp_pressure_compensation bptc_checker u_bptc_checker (.*);
`default_nettype wire
